FILE: hdl/fpas_pkg.sv
// ----------------------------------------------------------------------------
// fpas_pkg: shared types and constants for the half-precision add/sub unit
// Holds the classification record passed from the front to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package fpas_pkg;

    localparam logic [15:0] SIGN_MASK = 16'h8000;
    localparam logic [15:0] INF_BITS  = 16'h7C00;
    localparam logic [15:0] NAN_BITS  = 16'h7FFF;
    localparam logic [15:0] INF2_BITS = 16'hF800;
    localparam int          QDEPTH    = 2;

    // magnitude operation class
    typedef enum logic [0:0] {
        OP_ADD = 1'b0,
        OP_SUB = 1'b1
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [15:0] sign;
        logic [14:0] mag_a;
        logic [14:0] mag_b;
    } t_item;

endpackage

`default_nettype wire

FILE: hdl/fp16_add_sub.sv
// ----------------------------------------------------------------------------
// fp16_add_sub: half-precision adder/subtractor, truncating
// Front end classifies, a two-entry queue decouples, back end computes.
// ----------------------------------------------------------------------------
// channel | signals                               | direction
// in      | i_valid/o_ready, i_kind, i_operand_*  | into block
// out     | o_valid/i_ready, o_result_bits        | out of block
//
// One transaction per clock sustained while the output is not stalled; the result
// passes through the front register, queue, align/add stage and normalize stage.
// Each stage's ready depends on its own state and the stage after it; the queue's ready depends only on its own count.
// Reset (synchronous, active low) empties all stages; no other state.
// Output stall backs up through the queue, then the front stops accepting.
`default_nettype none

module fp16_add_sub
    import fpas_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_kind,
    input  wire logic [15:0] i_operand_a,
    input  wire logic [15:0] i_operand_b,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [15:0]      o_result_bits
);

    logic  w_fv, w_fr, w_qv, w_qr;
    t_item w_fi, w_qi;

    fpas_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_kind       (i_kind),
        .i_operand_a  (i_operand_a),
        .i_operand_b  (i_operand_b),
        .o_item_valid (w_fv),
        .i_item_ready (w_fr),
        .o_item       (w_fi)
    );

    fpas_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fv),
        .o_ready (w_fr),
        .i_item  (w_fi),
        .o_valid (w_qv),
        .i_ready (w_qr),
        .o_item  (w_qi)
    );

    fpas_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_qv),
        .o_ready       (w_qr),
        .i_item        (w_qi),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_result_bits (o_result_bits)
    );

endmodule

`default_nettype wire

FILE: hdl/fpas_front.sv
// ----------------------------------------------------------------------------
// fpas_front: input stage
// Accepts a transaction, folds the selector into the sign of b and picks
// the add or subtract magnitude path.
// ----------------------------------------------------------------------------
`default_nettype none

module fpas_front
    import fpas_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_kind,
    input  wire logic [15:0] i_operand_a,
    input  wire logic [15:0] i_operand_b,
    output logic             o_item_valid,
    input  wire logic        i_item_ready,
    output t_item            o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  w_sb;

    assign o_ready      = !r_valid || i_item_ready;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;
    assign w_sb         = i_operand_b[15] ^ i_kind;

    always_comb begin
        n_item.op    = (i_operand_a[15] == w_sb) ? OP_ADD : OP_SUB;
        n_item.sign  = {i_operand_a[15], 15'd0};
        n_item.mag_a = i_operand_a[14:0];
        n_item.mag_b = i_operand_b[14:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/fpas_queue.sv
// ----------------------------------------------------------------------------
// fpas_queue: small FIFO between front and back end
// Two entries, registered storage, independent stall on each side.
// ----------------------------------------------------------------------------
`default_nettype none

module fpas_queue
    import fpas_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_item i_item,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_item      o_item
);

    localparam int PW = $clog2(QDEPTH);

    t_item         r_mem [QDEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_ready = (r_cnt != (PW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(w_push) - (PW+1)'(w_pop);
        end
        if (w_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PW+1)'(QDEPTH)) else $error("queue count overflow");
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == (PW+1)'(QDEPTH)) |-> !o_ready) else $error("full not stalled");
    a_empty_no_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> !o_valid) else $error("empty queue shows valid");

endmodule

`default_nettype wire

FILE: hdl/fpas_back.sv
// ----------------------------------------------------------------------------
// fpas_back: magnitude add/subtract and output register
// Two stages: align and add in the first, normalize/pack in the second.
// ----------------------------------------------------------------------------
`default_nettype none

module fpas_back
    import fpas_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_item       i_item,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [15:0]      o_result_bits
);

    // ---------------- stage 1: swap, specials, align, raw sum/diff ----------
    logic [15:0] a1, b1, bs, r1, rs;
    logic [15:0] w_sign;
    logic [4:0]  axa, bxa;
    logic [4:0]  sh5;
    logic        w_done;
    logic [15:0] w_res;
    logic        w_norm;  // sub path needing leading-zero normalize
    logic [11:0] w_m;
    logic [4:0]  w_e;

    always_comb begin
        w_sign = i_item.sign;
        w_done = 1'b1;
        w_res  = '0;
        w_norm = 1'b0;
        w_m    = '0;
        w_e    = '0;
        a1 = '0; b1 = '0; bs = '0; r1 = '0; rs = '0;
        axa = '0; bxa = '0; sh5 = '0;
        if (i_item.op == OP_ADD) begin
            a1 = {1'b0, i_item.mag_a};
            b1 = {1'b0, i_item.mag_b};
            if (a1 < b1) begin
                a1 = {1'b0, i_item.mag_b};
                b1 = {1'b0, i_item.mag_a};
            end
            axa = a1[14:10];
            bxa = b1[14:10];
            sh5 = axa - bxa;
            if (a1 >= INF_BITS) begin
                w_res = (a1 > INF_BITS) ? NAN_BITS : (w_sign | INF_BITS);
            end else if (axa == bxa && bxa == 5'd0) begin
                w_res = (a1 + b1) | w_sign;
            end else begin
                if (axa != bxa) begin
                    if (bxa != 5'd0) bs = {5'd0, 1'b1, b1[9:0]} >> sh5;
                    else             bs = b1 >> (sh5 - 5'd1);
                end else begin
                    bs = {5'd0, 1'b1, b1[9:0]};
                end
                r1 = a1 + bs;
                if (r1[15:10] != {1'b0, axa}) begin
                    rs = ({5'd0, 1'b1, a1[9:0]} + bs) >> 1;
                    r1 = {1'b0, axa + 5'd1, rs[9:0]};
                    if (axa == 5'd30) r1 = INF_BITS;
                end
                w_res = (r1 >= INF_BITS) ? (w_sign | INF_BITS) : (r1 | w_sign);
            end
        end else begin
            a1 = {i_item.mag_a, 1'b0};
            b1 = {i_item.mag_b, 1'b0};
            if (a1 < b1) begin
                a1 = {i_item.mag_b, 1'b0};
                b1 = {i_item.mag_a, 1'b0};
                w_sign = w_sign ^ SIGN_MASK;
            end
            axa = a1[15:11];
            bxa = b1[15:11];
            sh5 = axa - bxa;
            if (a1 >= INF2_BITS) begin
                w_res = (a1 > INF2_BITS || a1 == b1) ? NAN_BITS : (w_sign | INF_BITS);
            end else if (axa == bxa && bxa == 5'd0) begin
                rs    = (a1 - b1) >> 1;
                w_res = (rs == '0) ? 16'd0 : (rs | w_sign);
            end else begin
                if (axa != bxa) begin
                    if (bxa != 5'd0) bs = {4'd0, 1'b1, b1[10:0]} >> sh5;
                    else             bs = b1 >> (sh5 - 5'd1);
                end else begin
                    bs = {4'd0, 1'b1, b1[10:0]};
                end
                r1 = a1 - bs;
                if (r1[15:11] == axa) begin
                    w_res = (r1 >> 1) | w_sign;
                end else begin
                    rs = {4'd0, 1'b1, a1[10:0]} - bs;
                    w_m = rs[11:0];
                    w_e = axa;
                    if (w_m == '0) begin
                        w_res = '0;
                    end else begin
                        w_done = 1'b0;
                        w_norm = 1'b1;
                    end
                end
            end
        end
    end

    logic        r1_valid;
    logic        r1_norm;
    logic [15:0] r1_res;
    logic [15:0] r1_sign;
    logic [11:0] r1_m;
    logic [4:0]  r1_e;
    logic        w_s1_ready;

    // ---------------- stage 2: leading-zero normalize --------------------
    // e steps down while the hidden bit is clear; m shifts unless e hits 0.
    logic [3:0]  w_lz;
    logic [4:0]  w_sh;
    logic [11:0] w_mn;
    logic [4:0]  w_en;
    logic [15:0] w_out;

    always_comb begin
        w_lz = 4'd12;
        for (int i = 0; i < 12; i++) begin
            if (r1_m[i]) w_lz = 4'(11 - i);
        end
        if ({1'b0, w_lz} < r1_e) begin
            w_en = r1_e - {1'b0, w_lz};
            w_sh = {1'b0, w_lz};
        end else begin
            w_en = '0;
            w_sh = r1_e - 5'd1;
        end
        w_mn  = r1_m << w_sh;
        w_out = r1_norm ? (({5'd0, w_mn[10:0]} | {w_en, 11'd0}) >> 1) | r1_sign
                        : r1_res;
    end

    logic        r2_valid;
    logic [15:0] r2_res;

    assign w_s1_ready    = !r2_valid || i_ready;
    assign o_ready       = !r1_valid || w_s1_ready;
    assign o_valid       = r2_valid;
    assign o_result_bits = r2_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            if (o_ready)    r1_valid <= i_valid;
            if (w_s1_ready) r2_valid <= r1_valid;
        end
        if (o_ready && i_valid) begin
            r1_norm <= w_norm && !w_done;
            r1_res  <= w_res;
            r1_sign <= w_sign;
            r1_m    <= w_m;
            r1_e    <= w_e;
        end
        if (w_s1_ready && r1_valid) begin
            r2_res <= w_out;
        end
    end

    a_norm_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r1_valid && r1_norm) |-> (r1_m != '0 && r1_e != '0))
        else $error("normalize with zero mantissa");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_result_bits)))
        else $error("result dropped under stall");
    a_nan_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_bits[14:10] == 5'h1F && o_result_bits[9:0] != '0)
        |-> (o_result_bits == NAN_BITS)) else $error("non canonical NaN");

endmodule

`default_nettype wire

FILE: verif/fp16_add_sub_checker.sv
// ----------------------------------------------------------------------------
// fp16_add_sub_checker: result predictor and scoreboard for fp16_add_sub
// Watches both channels, computes the expected half-precision sum/difference
// for each accepted operation and compares it with each accepted result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fp16_add_sub_checker
    import fpas_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        i_in_ready,
    input  wire logic        i_kind,
    input  wire logic [15:0] i_operand_a,
    input  wire logic [15:0] i_operand_b,
    input  wire logic        i_out_valid,
    input  wire logic        i_ready,
    input  wire logic [15:0] i_result_bits,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_ops_seen,
    output int               o_results_seen
);

    logic [15:0] expected_sums[$];

    function automatic logic [15:0] add_magnitudes(logic [31:0] a, logic [31:0] b,
                                                   logic [31:0] sgn);
        logic [31:0] t, ax, bx, r, m, sh;
        if (a < b) begin
            t = a; a = b; b = t;
        end
        if (a >= 32'(INF_BITS) || b >= 32'(INF_BITS)) begin
            if (a > 32'(INF_BITS) || b > 32'(INF_BITS)) return NAN_BITS;
            return 16'(sgn) | INF_BITS;
        end
        ax = a >> 10;
        bx = b >> 10;
        if (ax != bx) begin
            sh = ax - bx;
            if (bx != 0) b = ((b & 32'd1023) | 32'd1024) >> sh;
            else b = b >> (sh - 1);
        end else begin
            if (bx == 0) return 16'((a + b) | sgn);
            b = (b & 32'd1023) | 32'd1024;
        end
        r = a + b;
        if ((r >> 10) != ax) begin
            m = (((a & 32'd1023) | 32'd1024) + b) >> 1;
            r = ((ax + 1) << 10) | (m & 32'd1023);
        end
        if (r >= 32'(INF_BITS)) return 16'(sgn) | INF_BITS;
        return 16'(r | sgn);
    endfunction

    function automatic logic [15:0] sub_magnitudes(logic [31:0] a, logic [31:0] b,
                                                   logic [31:0] sgn);
        logic [31:0] t, ax, bx, r, m, e, sh;
        a = (a << 1) & 32'hFFFF;
        b = (b << 1) & 32'hFFFF;
        if (a < b) begin
            t = a; a = b; b = t;
            sgn ^= 32'(SIGN_MASK);
        end
        if (a >= 32'(INF2_BITS) || b >= 32'(INF2_BITS)) begin
            if (a > 32'(INF2_BITS) || b > 32'(INF2_BITS) || a == b) return NAN_BITS;
            return 16'(sgn) | INF_BITS;
        end
        ax = a & 32'hF800;
        bx = b & 32'hF800;
        if (ax != bx) begin
            sh = (ax - bx) >> 11;
            if (bx != 0) b = ((b & 32'd2047) | 32'd2048) >> sh;
            else b = b >> (sh - 1);
        end else begin
            if (bx == 0) begin
                r = (a - b) >> 1;
                if (r == 0) return 16'h0000;
                return 16'(r | sgn);
            end
            b = (b & 32'd2047) | 32'd2048;
        end
        r = (a - b) & 32'hFFFF;
        if ((r & 32'hF800) == ax) return 16'((r >> 1) | sgn);
        m = ((a & 32'd2047) | 32'd2048) - b;
        if (m == 0) return 16'h0000;
        e = ax;
        while (e != 0 && (m & 32'd2048) == 0) begin
            e -= 32'h800;
            if (e != 0) m <<= 1;
        end
        return 16'((((m & 32'd2047) | e) >> 1) | sgn);
    endfunction

    function automatic logic [15:0] half_add_sub(logic kind, logic [15:0] a, logic [15:0] b);
        logic [15:0] bb;
        bb = b ^ {kind, 15'd0};
        if (a[15] == bb[15])
            return add_magnitudes({17'd0, a[14:0]}, {17'd0, bb[14:0]}, {16'd0, a & SIGN_MASK});
        return sub_magnitudes({17'd0, a[14:0]}, {17'd0, bb[14:0]}, {16'd0, a & SIGN_MASK});
    endfunction

    always @(posedge i_clk) begin
        logic [15:0] want;
        if (!i_rst_n) begin
            expected_sums.delete();
            o_fail_count   <= 0;
            o_ops_seen     <= 0;
            o_results_seen <= 0;
        end else begin
            if (i_valid && i_in_ready) begin
                expected_sums.push_back(half_add_sub(i_kind, i_operand_a, i_operand_b));
                o_ops_seen <= o_ops_seen + 1;
            end
            if (i_out_valid && i_ready) begin
                o_results_seen <= o_results_seen + 1;
                if (expected_sums.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result %h with nothing pending", i_result_bits);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_sums.pop_front();
                    if (want !== i_result_bits) begin
                        if (o_fail_count < 10)
                            $display("mismatch: expected %h actual %h", want, i_result_bits);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= expected_sums.size();
    end

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for fp16_add_sub
// Directed special cases, then random operands biased toward interesting
// exponents, with random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import fpas_pkg::*;

    localparam int N_RANDOM = 1330;
    localparam int WATCHDOG = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_kind = 1'b0;
    logic [15:0] op_a = '0;
    logic [15:0] op_b = '0;
    logic        out_ready = 1'b0;
    logic        in_ready, out_valid;
    logic [15:0] result_bits;
    int          fail_count, pending, ops_seen, results_seen;
    int          idle_pct = 23;
    bit          hold_off = 1'b0;
    int          quiet_cycles = 0;

    fp16_add_sub dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_ready(in_ready),
        .i_kind(in_kind), .i_operand_a(op_a), .i_operand_b(op_b),
        .o_valid(out_valid), .i_ready(out_ready), .o_result_bits(result_bits)
    );

    fp16_add_sub_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_in_ready(in_ready),
        .i_kind(in_kind), .i_operand_a(op_a), .i_operand_b(op_b),
        .i_out_valid(out_valid), .i_ready(out_ready), .i_result_bits(result_bits),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_ops_seen(ops_seen), .o_results_seen(results_seen)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge clk) begin
        if (!rst_n || hold_off) out_ready <= 1'b0;
        else out_ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [15:0] pick_half();
        logic [4:0] ex;
        case ($urandom_range(9))
            0: ex = 5'd0;
            1: ex = 5'd31;
            2: ex = 5'd30;
            3: ex = 5'd1;
            default: ex = 5'($urandom_range(31));
        endcase
        return {1'($urandom), ex, 10'($urandom)};
    endfunction

    // called at a falling edge; valid stays up between back-to-back items
    task automatic send_op(logic kind, logic [15:0] a, logic [15:0] b);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_kind  <= kind;
        op_a     <= a;
        op_b     <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    initial begin
        logic [15:0] a, b;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: zeros, NaNs, infinities, subnormals, overflow, cancellation
        send_op(OP_ADD, 16'h0000, 16'h0000);
        send_op(OP_ADD, 16'h8000, 16'h8000);
        send_op(OP_SUB, 16'h0000, 16'h0000);
        send_op(OP_ADD, 16'h7E00, 16'h3C00);
        send_op(OP_SUB, 16'h3C00, 16'hFFFF);
        send_op(OP_ADD, 16'h7C00, 16'hFC00);
        send_op(OP_SUB, 16'h7C00, 16'h7C00);
        send_op(OP_ADD, 16'h7C00, 16'h4000);
        send_op(OP_SUB, 16'h4000, 16'h7C00);
        send_op(OP_ADD, 16'h7BFF, 16'h7BFF);
        send_op(OP_SUB, 16'hFBFF, 16'h7BFF);
        send_op(OP_ADD, 16'h3C00, 16'h3C00);
        send_op(OP_ADD, 16'h3FFF, 16'h3C01);
        send_op(OP_SUB, 16'h4321, 16'h4321);
        send_op(OP_SUB, 16'h3C00, 16'h3BFF);
        send_op(OP_ADD, 16'h03FF, 16'h0001);
        send_op(OP_SUB, 16'h0400, 16'h0001);
        send_op(OP_ADD, 16'h0200, 16'h8100);
        send_op(OP_ADD, 16'h7800, 16'h0001);
        send_op(OP_SUB, 16'h0001, 16'h7BFF);
        send_op(OP_ADD, 16'hFFFF, 16'h0000);

        // long output hold-off while the sender keeps offering items
        hold_off = 1'b1;
        fork
            begin
                repeat (60) @(posedge clk);
                hold_off = 1'b0;
            end
            repeat (20) send_op(1'($urandom), pick_half(), pick_half());
        join

        for (int i = 0; i < N_RANDOM; i++) begin
            // a stretch with no idling at all
            idle_pct = (i >= 400 && i < 600) ? 0 : 23;
            a = pick_half();
            b = ($urandom_range(4) == 0) ? {1'($urandom), a[14:0] ^ 15'($urandom_range(3))}
                                         : pick_half();
            send_op(1'($urandom), a, b);
        end
        in_valid <= 1'b0;
        idle_pct = 23;

        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        $display("Covered %0d add/sub operations, %0d results checked, incl. NaN, inf,",
                 ops_seen, results_seen);
        $display("subnormal, overflow and cancellation cases under random backpressure.");
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
